// File: hw/rtl/sfc_pkg.sv
// sfc_pkg: shared types and constants for the sbus frame codec
// holds the command and result transfer structs, opcode and result kind codes
// and the control structs between the sequencer and the shared bit accumulator
package sfc_pkg;

    localparam int NUM_CH      = 16;
    localparam int CH_W        = 11;
    localparam int PAYLOAD_LEN = 22;
    localparam int FRAME_LEN   = 25;
    localparam int ACC_W       = 18;
    localparam int CNT_W       = 5;
    localparam int IDX_W       = 5;

    localparam logic [7:0]      HDR_BYTE  = 8'h0F;
    localparam logic [7:0]      FOOT_BYTE = 8'h00;
    localparam logic [7:0]      FLAG_BYTE = 8'h00;
    localparam logic [15:0]     CH_MAX    = 16'd2047;
    localparam logic [CH_W-1:0] CH_RESET  = 11'd1023;

    localparam logic [IDX_W-1:0] RX_LAST_POS = IDX_W'(FRAME_LEN - 1);
    localparam logic [IDX_W-1:0] TX_BODY_END = IDX_W'(PAYLOAD_LEN);
    localparam logic [IDX_W-1:0] TX_LAST_CNT = IDX_W'(FRAME_LEN - 1);
    localparam logic [IDX_W-1:0] CH_LAST     = IDX_W'(NUM_CH - 1);

    typedef enum logic [1:0] {
        OP_SET  = 2'd0,
        OP_RXB  = 2'd1,
        OP_SEND = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_CHAN   = 2'd1,
        KIND_TX     = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ACC_HOLD   = 3'd0,
        ACC_CLEAR  = 3'd1,
        ACC_PUSH8  = 3'd2,
        ACC_PUSH11 = 3'd3,
        ACC_POP8   = 3'd4,
        ACC_POP11  = 3'd5
    } acc_op_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  channel;
        logic [15:0] value;
        logic [7:0]  rx_byte;
    } cmd_t;

    typedef struct packed {
        logic [1:0]      kind;
        logic            status;
        logic [3:0]      channel_index;
        logic [CH_W-1:0] channel_value;
        logic [7:0]      tx_byte;
        logic            last;
    } res_t;

    typedef struct packed {
        acc_op_t         op;
        logic [CH_W-1:0] data;
    } acc_cmd_t;

    typedef struct packed {
        logic [CH_W-1:0]  bits;
        logic [CNT_W-1:0] cnt;
    } acc_stat_t;

endpackage

// File: hw/rtl/sfc_bitacc.sv
// sfc_bitacc: shared bit accumulator for frame packing and unpacking
// pushes 8 or 11 bits above the held bits and pops 8 or 11 from the bottom
// depends on sfc_pkg
module sfc_bitacc (
    input  logic              clk,
    input  logic              rst_n,
    input  sfc_pkg::acc_cmd_t acc_cmd,
    output sfc_pkg::acc_stat_t acc_stat
);
    import sfc_pkg::*;

    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_comb
    begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        case (acc_cmd.op)
            ACC_CLEAR:
            begin
                acc_next = '0;
                cnt_next = '0;
            end
            ACC_PUSH8:
            begin
                acc_next = acc_reg | (ACC_W'(acc_cmd.data[7:0]) << cnt_reg);
                cnt_next = cnt_reg + CNT_W'(8);
            end
            ACC_PUSH11:
            begin
                acc_next = acc_reg | (ACC_W'(acc_cmd.data) << cnt_reg);
                cnt_next = cnt_reg + CNT_W'(CH_W);
            end
            ACC_POP8:
            begin
                acc_next = acc_reg >> 8;
                cnt_next = cnt_reg - CNT_W'(8);
            end
            ACC_POP11:
            begin
                acc_next = acc_reg >> CH_W;
                cnt_next = cnt_reg - CNT_W'(CH_W);
            end
            default:
            begin
                acc_next = acc_reg;
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign acc_stat.bits = acc_reg[CH_W-1:0];
    assign acc_stat.cnt  = cnt_reg;

endmodule

// File: hw/rtl/sfc_seq.sv
// sfc_seq: command sequencer with the channel store and the receive deframer
// drives the shared bit accumulator and produces one result per emit
// depends on sfc_pkg
module sfc_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  sfc_pkg::cmd_t      cmd,
    output logic               cmd_stall,
    input  logic               emit_ok,
    output logic               emit_en,
    output sfc_pkg::res_t      emit_data,
    output sfc_pkg::acc_cmd_t  acc_cmd,
    input  sfc_pkg::acc_stat_t acc_stat
);
    import sfc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RX_UNPACK,
        S_TX_HDR,
        S_TX_BODY,
        S_TX_TAIL
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CH_W-1:0]  ch_store_reg [NUM_CH];
    logic [CH_W-1:0]  ch_store_next [NUM_CH];
    logic [7:0]       rx_buf_reg [PAYLOAD_LEN];
    logic [IDX_W-1:0] rx_pos_reg;
    logic [IDX_W-1:0] rx_pos_next;
    logic [IDX_W-1:0] ch_idx_reg;
    logic [IDX_W-1:0] ch_idx_next;
    logic [IDX_W-1:0] byte_idx_reg;
    logic [IDX_W-1:0] byte_idx_next;
    logic [IDX_W-1:0] tx_cnt_reg;
    logic [IDX_W-1:0] tx_cnt_next;
    logic             buf_we;
    logic [IDX_W-1:0] buf_waddr;
    logic             cmd_take;

    assign cmd_stall = (state_reg != S_IDLE) || !emit_ok;
    assign cmd_take  = cmd_valid && !cmd_stall;

    always_comb
    begin
        state_next    = state_reg;
        ch_store_next = ch_store_reg;
        rx_pos_next   = rx_pos_reg;
        ch_idx_next   = ch_idx_reg;
        byte_idx_next = byte_idx_reg;
        tx_cnt_next   = tx_cnt_reg;
        buf_we        = 1'b0;
        buf_waddr     = rx_pos_reg - IDX_W'(1);
        emit_en       = 1'b0;
        emit_data     = '0;
        acc_cmd.op    = ACC_HOLD;
        acc_cmd.data  = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_take)
                begin
                    case (cmd.opcode)
                        OP_SET:
                        begin
                            emit_en        = 1'b1;
                            emit_data.kind = KIND_STATUS;
                            emit_data.last = 1'b1;
                            if (cmd.value > CH_MAX)
                            begin
                                emit_data.status = 1'b1;
                            end
                            else
                            begin
                                ch_store_next[cmd.channel] = cmd.value[CH_W-1:0];
                            end
                        end
                        OP_RXB:
                        begin
                            if (rx_pos_reg == '0)
                            begin
                                if (cmd.rx_byte == HDR_BYTE)
                                begin
                                    rx_pos_next = IDX_W'(1);
                                end
                            end
                            else if (rx_pos_reg == RX_LAST_POS)
                            begin
                                rx_pos_next = '0;
                                if (cmd.rx_byte == FOOT_BYTE)
                                begin
                                    acc_cmd.op    = ACC_CLEAR;
                                    ch_idx_next   = '0;
                                    byte_idx_next = '0;
                                    state_next    = S_RX_UNPACK;
                                end
                            end
                            else
                            begin
                                // flags byte is not kept
                                buf_we      = (rx_pos_reg <= TX_BODY_END);
                                rx_pos_next = rx_pos_reg + IDX_W'(1);
                            end
                        end
                        OP_SEND:
                        begin
                            acc_cmd.op  = ACC_CLEAR;
                            ch_idx_next = '0;
                            tx_cnt_next = '0;
                            state_next  = S_TX_HDR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RX_UNPACK:
            begin
                if (acc_stat.cnt >= CNT_W'(CH_W))
                begin
                    if (emit_ok)
                    begin
                        emit_en                 = 1'b1;
                        emit_data.kind          = KIND_CHAN;
                        emit_data.channel_index = ch_idx_reg[3:0];
                        emit_data.channel_value = acc_stat.bits;
                        emit_data.last          = (ch_idx_reg == CH_LAST);
                        ch_store_next[ch_idx_reg[3:0]] = acc_stat.bits;
                        acc_cmd.op  = ACC_POP11;
                        ch_idx_next = ch_idx_reg + IDX_W'(1);
                        if (ch_idx_reg == CH_LAST)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
                else
                begin
                    acc_cmd.op    = ACC_PUSH8;
                    acc_cmd.data  = CH_W'(rx_buf_reg[byte_idx_reg]);
                    byte_idx_next = byte_idx_reg + IDX_W'(1);
                end
            end
            S_TX_HDR:
            begin
                if (emit_ok)
                begin
                    emit_en           = 1'b1;
                    emit_data.kind    = KIND_TX;
                    emit_data.tx_byte = HDR_BYTE;
                    tx_cnt_next       = tx_cnt_reg + IDX_W'(1);
                    state_next        = S_TX_BODY;
                end
            end
            S_TX_BODY:
            begin
                if (acc_stat.cnt >= CNT_W'(8))
                begin
                    if (emit_ok)
                    begin
                        emit_en           = 1'b1;
                        emit_data.kind    = KIND_TX;
                        emit_data.tx_byte = acc_stat.bits[7:0];
                        acc_cmd.op        = ACC_POP8;
                        tx_cnt_next       = tx_cnt_reg + IDX_W'(1);
                        if (tx_cnt_reg == TX_BODY_END)
                        begin
                            state_next = S_TX_TAIL;
                        end
                    end
                end
                else
                begin
                    acc_cmd.op   = ACC_PUSH11;
                    acc_cmd.data = ch_store_reg[ch_idx_reg[3:0]];
                    ch_idx_next  = ch_idx_reg + IDX_W'(1);
                end
            end
            S_TX_TAIL:
            begin
                if (emit_ok)
                begin
                    emit_en        = 1'b1;
                    emit_data.kind = KIND_TX;
                    // flags byte then footer
                    emit_data.tx_byte = (tx_cnt_reg == TX_LAST_CNT) ? FOOT_BYTE : FLAG_BYTE;
                    emit_data.last    = (tx_cnt_reg == TX_LAST_CNT);
                    tx_cnt_next       = tx_cnt_reg + IDX_W'(1);
                    if (tx_cnt_reg == TX_LAST_CNT)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            rx_pos_reg   <= '0;
            ch_idx_reg   <= '0;
            byte_idx_reg <= '0;
            tx_cnt_reg   <= '0;
            for (int i = 0; i < NUM_CH; i++)
            begin
                ch_store_reg[i] <= CH_RESET;
            end
        end
        else
        begin
            state_reg    <= state_next;
            rx_pos_reg   <= rx_pos_next;
            ch_idx_reg   <= ch_idx_next;
            byte_idx_reg <= byte_idx_next;
            tx_cnt_reg   <= tx_cnt_next;
            ch_store_reg <= ch_store_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            rx_buf_reg[buf_waddr] <= cmd.rx_byte;
        end
    end

endmodule

// File: hw/rtl/sbus_frame_codec.sv
// sbus_frame_codec: top level of the sbus frame codec
// joins the sequencer, the shared bit accumulator and the result register
// depends on sfc_pkg, sfc_bitacc and sfc_seq
//
// usage: commands arrive on cmd (cmd_valid / cmd_stall), results leave on
// res (res_valid / res_stall); a transfer happens when valid is high and
// stall is low. a set-channel command gives one status result, registered
// in the cycle after its transfer. a received byte gives no result except
// the footer of a good frame, which starts an unpack of 22 byte loads and
// 16 channel results in the accumulator. a send command gives a header,
// 16 channel loads with 22 byte results, flags and footer. the bit
// accumulator is shared by packing and unpacking; one command is worked
// on at a time and cmd_stall is high until its last result is in the
// result register. the next command is taken in a cycle where the result
// register is empty or its result is transferred; a held result keeps
// cmd_stall high. a stalled receiver freezes the sequence without loss.
// reset sets all channels to 1023, puts the deframer back to header
// hunting and empties the result register.
module sbus_frame_codec (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  sfc_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_stall,
    output sfc_pkg::res_t res
);
    import sfc_pkg::*;

    acc_cmd_t  acc_cmd;
    acc_stat_t acc_stat;
    logic      emit_ok;
    logic      emit_en;
    res_t      emit_data;
    logic      res_valid_reg;
    res_t      res_reg;

    assign emit_ok = !res_valid_reg || !res_stall;

    sfc_bitacc u_bitacc (
        .clk      (clk),
        .rst_n    (rst_n),
        .acc_cmd  (acc_cmd),
        .acc_stat (acc_stat)
    );

    sfc_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_stall (cmd_stall),
        .emit_ok   (emit_ok),
        .emit_en   (emit_en),
        .emit_data (emit_data),
        .acc_cmd   (acc_cmd),
        .acc_stat  (acc_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (emit_en)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_en)
        begin
            res_reg <= emit_data;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(emit_en && res_valid_reg && res_stall))
        else $error("result register overwritten while stalled");

    a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        acc_stat.cnt <= CNT_W'(ACC_W))
        else $error("bit accumulator overfilled");

    a_chan_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind == KIND_CHAN) |-> (res.last == (res.channel_index == 4'd15)))
        else $error("channel result last flag out of place");

    a_footer: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind == KIND_TX && res.last) |-> (res.tx_byte == FOOT_BYTE))
        else $error("frame does not end in footer");

    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall && cmd.opcode == OP_SEND) |=> cmd_stall)
        else $error("command taken during send");

endmodule
